### hw/rtl/psl_pkg.sv
// Package for the pair sort / longest increasing chain block.
// Holds the word types of both channels and the controller state type; no dependencies.
package psl_pkg;

  typedef struct packed {
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic        last_item;
  } psl_in_t;

  typedef struct packed {
    logic [12:0] chain_length;
    logic        overflow;
  } psl_out_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_BUILD_RD,
    S_BUILD_V,
    S_SORT_RD0,
    S_SORT_RDE,
    S_SORT_WR,
    S_SIFT_L,
    S_SIFT_R,
    S_SIFT_C,
    S_SIFT_END,
    S_LIS_RD,
    S_LIS_Y,
    S_BS,
    S_BC,
    S_DONE
  } psl_state_t;

endpackage

### hw/rtl/psl_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module psl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/pair_sort_lis_length.sv
// Top level of the pair sort / longest increasing chain block.
// Depends on psl_pkg and psl_ram.
//
// Pairs are taken one word per cycle while in_ready is high and written into
// the pair RAM; pairs beyond MAX_PAIRS are dropped and flagged. After the
// word marked last_item, in_ready stays low while the block heap-sorts the
// pairs in place by (x, y) and then runs a patience scan with a binary search
// over the tails RAM. The single read port of the pair RAM sets the sort time:
// each level of a sift reads the left child, reads the right child and then
// compares and writes, with further steps to set up and close each sift. In
// the scan, each pair is read and its y taken, then the binary search probes
// the tails RAM through its one read port. A finished result sits in an output
// register, so the next set may load while it waits; a new result waits in
// the last state until the previous one has been taken.
module pair_sort_lis_length
  import psl_pkg::*;
#(
  parameter int MAX_PAIRS  = 4096,
  parameter int COORD_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  psl_in_t  in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output psl_out_t out_word
);

  localparam int AW = $clog2(MAX_PAIRS);
  localparam int CB = COORD_BITS;
  localparam int KW = 2 * COORD_BITS;
  localparam logic [AW:0] MAXC = (AW + 1)'(MAX_PAIRS);

  psl_state_t state, state_next;

  logic          phase_sort;
  logic [AW:0]   cnt;
  logic          dropped;
  logic [AW:0]   idx;
  logic [AW-1:0] p;
  logic [AW:0]   size;
  logic [KW-1:0] v;
  logic [KW-1:0] lval;
  logic [KW-1:0] t;
  logic [CB-1:0] y;
  logic [AW:0]   len;
  logic [AW:0]   lo;
  logic [AW:0]   hi;
  logic [AW-1:0] mid;

  // Pair RAM ports.
  logic          pr_we;
  logic [AW-1:0] pr_waddr;
  logic [KW-1:0] pr_wdata;
  logic [AW-1:0] pr_raddr;
  logic [KW-1:0] pr_rdata;

  // Tails RAM ports.
  logic          tr_we;
  logic [AW-1:0] tr_waddr;
  logic [CB-1:0] tr_wdata;
  logic [AW-1:0] tr_raddr;
  logic [CB-1:0] tr_rdata;

  psl_ram #(.WIDTH(KW), .DEPTH(MAX_PAIRS)) u_pair_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );

  psl_ram #(.WIDTH(CB), .DEPTH(MAX_PAIRS)) u_tail_ram (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );

  // Incoming key, coordinates masked to COORD_BITS.
  logic [31:0]   xw, yw;
  logic [KW-1:0] in_key;
  assign xw     = 32'(in_word.coord_x);
  assign yw     = 32'(in_word.coord_y);
  assign in_key = {xw[CB-1:0], yw[CB-1:0]};

  logic in_acc, out_free, has_room;
  assign in_ready = (state == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign has_room = (cnt < MAXC);

  // Child positions of the sift hole and the sift comparison.
  logic [AW+1:0] lc, rc, size_w;
  logic          lc_in, rc_in;
  assign lc     = {1'b0, p, 1'b1};
  assign rc     = lc + 1'b1;
  assign size_w = {1'b0, size};
  assign lc_in  = (lc < size_w);
  assign rc_in  = (rc < size_w);

  logic [AW-1:0] big_pos;
  logic [KW-1:0] big_val;
  logic          big_is_p;
  always_comb begin
    big_pos  = p;
    big_val  = v;
    big_is_p = 1'b1;
    if (lval > v) begin
      big_pos  = lc[AW-1:0];
      big_val  = lval;
      big_is_p = 1'b0;
    end
    if (rc_in && (pr_rdata > big_val)) begin
      big_pos  = rc[AW-1:0];
      big_val  = pr_rdata;
      big_is_p = 1'b0;
    end
  end

  logic [AW:0]   idx_m1, idx_p1, lo_p1;
  logic [AW+1:0] mid_sum;
  assign idx_m1  = idx - 1'b1;
  assign idx_p1  = idx + 1'b1;
  assign lo_p1   = lo + 1'b1;
  assign mid_sum = ({1'b0, lo} + {1'b0, hi}) >> 1;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:     if (in_acc && in_word.last_item) state_next = S_START;
      S_START:    state_next = (cnt < (AW + 1)'(2)) ? S_LIS_RD : S_BUILD_RD;
      S_BUILD_RD: state_next = S_BUILD_V;
      S_BUILD_V:  state_next = S_SIFT_L;
      S_SORT_RD0: state_next = S_SORT_RDE;
      S_SORT_RDE: state_next = S_SORT_WR;
      S_SORT_WR:  state_next = S_SIFT_L;
      S_SIFT_L:   state_next = lc_in ? S_SIFT_R : S_SIFT_END;
      S_SIFT_R:   state_next = S_SIFT_C;
      S_SIFT_C:   state_next = big_is_p ? S_SIFT_END : S_SIFT_L;
      S_SIFT_END: begin
        if (!phase_sort) begin
          state_next = (idx == (AW + 1)'(1)) ? S_SORT_RD0 : S_BUILD_RD;
        end else begin
          state_next = (idx == (AW + 1)'(1)) ? S_LIS_RD : S_SORT_RD0;
        end
      end
      S_LIS_RD:   state_next = S_LIS_Y;
      S_LIS_Y:    state_next = S_BS;
      S_BS: begin
        if (lo < hi) begin
          state_next = S_BC;
        end else begin
          state_next = (idx_p1 == cnt) ? S_DONE : S_LIS_RD;
        end
      end
      S_BC:       state_next = S_BS;
      S_DONE:     if (out_free) state_next = S_LOAD;
      default:    state_next = S_LOAD;
    endcase
  end

  // RAM controls.
  always_comb begin
    pr_we    = 1'b0;
    pr_waddr = p;
    pr_wdata = v;
    pr_raddr = idx[AW-1:0];
    tr_we    = 1'b0;
    tr_waddr = lo[AW-1:0];
    tr_wdata = y;
    tr_raddr = mid_sum[AW-1:0];
    case (state)
      S_LOAD: begin
        pr_we    = in_acc && has_room;
        pr_waddr = cnt[AW-1:0];
        pr_wdata = in_key;
      end
      S_BUILD_RD: pr_raddr = idx_m1[AW-1:0];
      S_SORT_RD0: pr_raddr = '0;
      S_SORT_RDE: pr_raddr = idx[AW-1:0];
      S_SORT_WR: begin
        pr_we    = 1'b1;
        pr_waddr = idx[AW-1:0];
        pr_wdata = t;
      end
      S_SIFT_L: begin
        pr_raddr = lc[AW-1:0];
        pr_we    = !lc_in;
      end
      S_SIFT_R:   pr_raddr = rc[AW-1:0];
      S_SIFT_C: begin
        pr_we    = 1'b1;
        pr_wdata = big_is_p ? v : big_val;
      end
      S_BS:       tr_we = !(lo < hi);
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // In the last state a taken result is replaced by the new one below.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              cnt <= cnt + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            cnt       <= '0;
            dropped   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  logic [31:0] len_w;
  assign len_w = 32'(len);

  always_ff @(posedge clk) begin
    case (state)
      S_START: begin
        phase_sort <= 1'b0;
        len        <= '0;
        if (cnt < (AW + 1)'(2)) begin
          idx <= '0;
        end else begin
          idx <= cnt >> 1;
        end
      end
      S_BUILD_RD: begin
        p    <= idx_m1[AW-1:0];
        size <= cnt;
      end
      S_BUILD_V:  v <= pr_rdata;
      S_SORT_RDE: t <= pr_rdata;
      S_SORT_WR: begin
        v    <= pr_rdata;
        p    <= '0;
        size <= idx;
      end
      S_SIFT_R:   lval <= pr_rdata;
      S_SIFT_C:   if (!big_is_p) p <= big_pos;
      S_SIFT_END: begin
        if (!phase_sort) begin
          if (idx == (AW + 1)'(1)) begin
            phase_sort <= 1'b1;
            idx        <= cnt - 1'b1;
          end else begin
            idx <= idx_m1;
          end
        end else begin
          if (idx == (AW + 1)'(1)) begin
            idx <= '0;
            len <= '0;
          end else begin
            idx <= idx_m1;
          end
        end
      end
      S_LIS_Y: begin
        y  <= pr_rdata[CB-1:0];
        lo <= '0;
        hi <= len;
      end
      S_BS: begin
        if (lo < hi) begin
          mid <= mid_sum[AW-1:0];
        end else begin
          if (lo_p1 > len) len <= lo_p1;
          idx <= idx_p1;
        end
      end
      S_BC: begin
        if (tr_rdata < y) begin
          lo <= {1'b0, mid} + 1'b1;
        end else begin
          hi <= {1'b0, mid};
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_word.chain_length <= len_w[12:0];
          out_word.overflow     <= dropped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hw/rtl/psl_checker.sv
// Port-level checker for pair_sort_lis_length, bound to the top level.
// Depends on psl_pkg.
module psl_checker
  import psl_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input psl_in_t  in_word,
  input logic     out_valid,
  input logic     out_ready,
  input psl_out_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_word.last_item |=> !in_ready)
    else $error("input still open after the last word of a set");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.chain_length != 13'd0)
    else $error("zero chain length reported");

endmodule

bind pair_sort_lis_length psl_checker u_psl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
  .out_word(out_word)
);
